// File: design/asci_pkg.sv
`timescale 1ns / 1ps

package asci_pkg;

   // fixed field widths
   localparam int PIX_W      = 13;
   localparam int STICK_W    = 16;
   localparam int DT_W       = 16;
   localparam int SPEED_W    = 16;
   localparam int AREA_W     = 14;
   localparam int OP_W       = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // shared arithmetic
   localparam int MUL_A_W      = 32;
   localparam int MUL_B_W      = 16;
   localparam int ACC_W        = 64;
   localparam int RAD_W        = 32;
   localparam int ROOT_W       = 16;
   localparam int PRODUCT_FRAC = 46;

   // 1e-6 in Q2.30, truncated
   localparam logic [RAD_W-1:0] DEADZONE_SQ = 32'd1073;
   localparam logic [RAD_W-1:0] SQRT_TOP_BIT = 32'h4000_0000;

   // register map
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 2'd2;

   localparam logic [SPEED_W-1:0] SPEED_RESET  = 16'd1200;
   localparam logic [AREA_W-1:0]  WIDTH_RESET  = 14'd640;
   localparam logic [AREA_W-1:0]  HEIGHT_RESET = 14'd480;

   // opcodes
   localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
   localparam logic [OP_W-1:0] OP_SET    = 2'd1;
   localparam logic [OP_W-1:0] OP_CENTER = 2'd2;

   typedef enum logic [1:0] {
      MAC_HOLD,
      MAC_LOAD,
      MAC_ADD,
      MAC_ADD_HI
   } mac_mode_type;

   typedef struct packed {
      mac_mode_type         mode;
      logic [MUL_A_W-1:0]   op_a;
      logic [MUL_B_W-1:0]   op_b;
   } mac_ctl_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ_X,
      ST_SQ_Y,
      ST_CHECK,
      ST_ROOT,
      ST_MUL_MAG,
      ST_MUL_SPEED,
      ST_MUL_DT_LO,
      ST_MUL_DT_HI,
      ST_APPLY,
      ST_PIXEL,
      ST_REPLY
   } state_type;

endpackage

// File: design/analog_stick_cursor_integrator.sv
`timescale 1ns / 1ps

// Analog stick cursor integrator. Keeps a cursor position per axis as unsigned
// fixed point (COORD_BITS integer, FRAC_BITS fraction bits) and returns exactly
// one response per request: the integer pixel and a moved flag. A tick (op 0)
// squares and sums the stick axes, takes an integer square root of that sum,
// then scales each axis by magnitude, speed and elapsed time through one
// shared 32x16 multiply-accumulate unit (four passes per axis) and adds the
// result to the position, clamped to the area. Ticks inside the dead zone or
// with zero elapsed time skip the root and the multiplies. Set position
// (op 1), center (op 2) and the unused op 3 resolve at accept and go straight
// to the response. The block takes one request at a time: req_ready is high
// only while no request is in work, and a new request may be accepted while
// the previous response still waits in the output register. Registers (speed,
// width, height) are written through the csr port, which is always ready;
// write them only while idle.
module analog_stick_cursor_integrator import asci_pkg::*; #(
   parameter int COORD_BITS = 13,
   parameter int FRAC_BITS  = 16
) (
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wdata,

   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [OP_W-1:0]           req_op,
   input  logic signed [STICK_W-1:0] req_stick_x,
   input  logic signed [STICK_W-1:0] req_stick_y,
   input  logic [DT_W-1:0]           req_elapsed,
   input  logic [PIX_W-1:0]          req_target_x,
   input  logic [PIX_W-1:0]          req_target_y,

   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [PIX_W-1:0]          rsp_cursor_x,
   output logic [PIX_W-1:0]          rsp_cursor_y,
   output logic                      rsp_moved
);

   // position word and effective area size
   localparam int FW   = COORD_BITS + FRAC_BITS;
   localparam int SZ_W = COORD_BITS + 1;
   // compare width for area saturation
   localparam int EW   = (AREA_W > SZ_W) ? AREA_W : SZ_W;
   localparam logic [EW-1:0] CAP = {{(EW-1){1'b0}}, 1'b1} << COORD_BITS;
   // compare width for target clamping
   localparam int TW   = (PIX_W > SZ_W) ? PIX_W : SZ_W;
   // delta magnitude after dropping the extra product fraction
   localparam int SHIFT = PRODUCT_FRAC - FRAC_BITS;
   localparam int DW    = ACC_W - SHIFT;
   // signed sum width, two guard bits
   localparam int SW    = ((FW > DW) ? FW : DW) + 2;

   // area register to effective size: zero means one, saturate at 2^COORD_BITS
   function automatic logic [SZ_W-1:0] eff_size(input logic [AREA_W-1:0] r);
      logic [EW-1:0] rx;
      rx = EW'(r);
      if (r == '0) begin
         return SZ_W'(1);
      end else if (rx > CAP) begin
         return SZ_W'(CAP);
      end else begin
         return SZ_W'(rx);
      end
   endfunction

   // target pixel clamped to size - 1
   function automatic logic [COORD_BITS-1:0] clamp_target(
      input logic [PIX_W-1:0] t,
      input logic [SZ_W-1:0]  size
   );
      logic [TW-1:0] tx;
      logic [TW-1:0] lim;
      tx  = TW'(t);
      lim = TW'(size - SZ_W'(1));
      return COORD_BITS'((tx > lim) ? lim : tx);
   endfunction

   // --------------------------------------------------------------------
   // state
   // --------------------------------------------------------------------
   state_type state_ff, state_in;

   logic [SPEED_W-1:0]    speed_ff;
   logic [AREA_W-1:0]     width_ff;
   logic [AREA_W-1:0]     height_ff;

   logic [FW-1:0]         fine_x_ff;
   logic [FW-1:0]         fine_y_ff;
   logic [COORD_BITS-1:0] pixel_x_ff;
   logic [COORD_BITS-1:0] pixel_y_ff;

   // latched tick operands: magnitude and sign per axis
   logic [STICK_W-1:0]    abs_x_ff;
   logic [STICK_W-1:0]    abs_y_ff;
   logic                  neg_x_ff;
   logic                  neg_y_ff;
   logic [DT_W-1:0]       dt_ff;
   logic [ROOT_W-1:0]     mag_ff;
   logic [MUL_B_W-1:0]    hi_ff;
   logic                  axis_ff;

   logic                  rsp_valid_ff;
   logic [PIX_W-1:0]      rsp_cursor_x_ff;
   logic [PIX_W-1:0]      rsp_cursor_y_ff;
   logic                  rsp_moved_ff;
   logic                  moved_ff;

   // --------------------------------------------------------------------
   // shared units
   // --------------------------------------------------------------------
   mac_ctl_type       mac_ctl;
   logic [ACC_W-1:0]  acc;
   logic              sqrt_start;
   logic              sqrt_busy;
   logic [ROOT_W-1:0] sqrt_root;

   asci_mac u_mac (
      .clock (clock),
      .ctl   (mac_ctl),
      .acc   (acc)
   );

   asci_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (acc[RAD_W-1:0]),
      .busy     (sqrt_busy),
      .root     (sqrt_root)
   );

   // --------------------------------------------------------------------
   // combinational helpers
   // --------------------------------------------------------------------
   logic [SZ_W-1:0]    size_w;
   logic [SZ_W-1:0]    size_h;
   logic               accept;
   logic               rsp_free;
   logic               dead;
   logic [STICK_W-1:0] stick_x_abs;
   logic [STICK_W-1:0] stick_y_abs;

   assign size_w   = eff_size(width_ff);
   assign size_h   = eff_size(height_ff);
   assign accept   = req_valid && req_ready;
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   // acc holds sx^2 + sy^2 (Q2.30) while in ST_CHECK
   assign dead     = (acc[RAD_W-1:0] <= DEADZONE_SQ) || (dt_ff == '0);

   assign stick_x_abs = req_stick_x[STICK_W-1] ? (~req_stick_x + 1'b1) : req_stick_x;
   assign stick_y_abs = req_stick_y[STICK_W-1] ? (~req_stick_y + 1'b1) : req_stick_y;

   // per-axis position update, used in ST_APPLY
   logic [FW-1:0]    cur_fine;
   logic [SZ_W-1:0]  cur_size;
   logic             cur_neg;
   logic [FW-1:0]    cur_lim;
   logic [DW-1:0]    delta_mag;
   logic [SW-1:0]    new_sum;
   logic [FW-1:0]    new_fine;

   assign cur_fine  = axis_ff ? fine_y_ff : fine_x_ff;
   assign cur_size  = axis_ff ? size_h : size_w;
   assign cur_neg   = axis_ff ? neg_y_ff : neg_x_ff;
   assign cur_lim   = {COORD_BITS'(cur_size - SZ_W'(1)), {FRAC_BITS{1'b0}}};
   // magnitude truncates toward zero before the sign goes back on
   assign delta_mag = acc[ACC_W-1:SHIFT];
   assign new_sum   = cur_neg ? (SW'(cur_fine) - SW'(delta_mag))
                              : (SW'(cur_fine) + SW'(delta_mag));

   always_comb begin
      priority if (new_sum[SW-1]) begin
         new_fine = '0;
      end else if (new_sum > SW'(cur_lim)) begin
         new_fine = cur_lim;
      end else begin
         new_fine = FW'(new_sum);
      end
   end

   logic [COORD_BITS-1:0] next_px;
   logic [COORD_BITS-1:0] next_py;

   assign next_px = fine_x_ff[FW-1:FRAC_BITS];
   assign next_py = fine_y_ff[FW-1:FRAC_BITS];

   // --------------------------------------------------------------------
   // sequencer: next state
   // --------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (req_valid) begin
                          state_in = (req_op == OP_TICK) ? ST_SQ_X : ST_REPLY;
                       end
         ST_SQ_X:      state_in = ST_SQ_Y;
         ST_SQ_Y:      state_in = ST_CHECK;
         ST_CHECK:     state_in = dead ? ST_REPLY : ST_ROOT;
         ST_ROOT:      if (!sqrt_busy) begin
                          state_in = ST_MUL_MAG;
                       end
         ST_MUL_MAG:   state_in = ST_MUL_SPEED;
         ST_MUL_SPEED: state_in = ST_MUL_DT_LO;
         ST_MUL_DT_LO: state_in = ST_MUL_DT_HI;
         ST_MUL_DT_HI: state_in = ST_APPLY;
         ST_APPLY:     state_in = axis_ff ? ST_PIXEL : ST_MUL_MAG;
         ST_PIXEL:     state_in = ST_REPLY;
         ST_REPLY:     if (rsp_free) begin
                          state_in = ST_IDLE;
                       end
         default:      state_in = ST_IDLE;
      endcase
   end

   // --------------------------------------------------------------------
   // sequencer: outputs (shared-unit control)
   // --------------------------------------------------------------------
   always_comb begin
      mac_ctl    = '{mode: MAC_HOLD, op_a: '0, op_b: '0};
      sqrt_start = 1'b0;
      req_ready  = 1'b0;
      unique case (state_ff)
         ST_IDLE:      req_ready = 1'b1;
         // sx^2, then + sy^2
         ST_SQ_X:      mac_ctl = '{mode: MAC_LOAD, op_a: MUL_A_W'(abs_x_ff), op_b: abs_x_ff};
         ST_SQ_Y:      mac_ctl = '{mode: MAC_ADD, op_a: MUL_A_W'(abs_y_ff), op_b: abs_y_ff};
         ST_CHECK:     sqrt_start = !dead;
         // |s| * mag
         ST_MUL_MAG:   mac_ctl = '{mode: MAC_LOAD,
                                   op_a: MUL_A_W'(axis_ff ? abs_y_ff : abs_x_ff),
                                   op_b: mag_ff};
         // * speed, 48-bit result
         ST_MUL_SPEED: mac_ctl = '{mode: MAC_LOAD, op_a: acc[MUL_A_W-1:0], op_b: speed_ff};
         // * dt in two partial products: low 32 bits now, high 16 bits next
         ST_MUL_DT_LO: mac_ctl = '{mode: MAC_LOAD, op_a: acc[MUL_A_W-1:0], op_b: dt_ff};
         ST_MUL_DT_HI: mac_ctl = '{mode: MAC_ADD_HI, op_a: MUL_A_W'(hi_ff), op_b: dt_ff};
         default:      ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // --------------------------------------------------------------------
   // configuration registers
   // --------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff  <= SPEED_RESET;
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SPEED:  speed_ff  <= csr_wdata[SPEED_W-1:0];
            CSR_WIDTH:  width_ff  <= csr_wdata[AREA_W-1:0];
            CSR_HEIGHT: height_ff <= csr_wdata[AREA_W-1:0];
            default:    ;
         endcase
      end
   end

   // --------------------------------------------------------------------
   // cursor position
   // --------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         fine_x_ff  <= '0;
         fine_y_ff  <= '0;
         pixel_x_ff <= '0;
         pixel_y_ff <= '0;
         moved_ff   <= 1'b0;
         axis_ff    <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               moved_ff <= 1'b0;
               axis_ff  <= 1'b0;
               if (accept && (req_op == OP_SET)) begin
                  fine_x_ff  <= {clamp_target(req_target_x, size_w), {FRAC_BITS{1'b0}}};
                  fine_y_ff  <= {clamp_target(req_target_y, size_h), {FRAC_BITS{1'b0}}};
                  pixel_x_ff <= clamp_target(req_target_x, size_w);
                  pixel_y_ff <= clamp_target(req_target_y, size_h);
               end else if (accept && (req_op == OP_CENTER)) begin
                  // exact half, fraction one half for odd sizes, no clamp
                  fine_x_ff  <= FW'({size_w, {FRAC_BITS{1'b0}}} >> 1);
                  fine_y_ff  <= FW'({size_h, {FRAC_BITS{1'b0}}} >> 1);
                  pixel_x_ff <= COORD_BITS'(size_w >> 1);
                  pixel_y_ff <= COORD_BITS'(size_h >> 1);
               end
            end
            ST_APPLY: begin
               if (axis_ff) begin
                  fine_y_ff <= new_fine;
               end else begin
                  fine_x_ff <= new_fine;
               end
               axis_ff <= 1'b1;
            end
            ST_PIXEL: begin
               moved_ff   <= (next_px != pixel_x_ff) || (next_py != pixel_y_ff);
               pixel_x_ff <= next_px;
               pixel_y_ff <= next_py;
            end
            default: ;
         endcase
      end
   end

   // tick operands and intermediate products
   always_ff @(posedge clock) begin
      if (accept) begin
         abs_x_ff <= stick_x_abs;
         abs_y_ff <= stick_y_abs;
         neg_x_ff <= req_stick_x[STICK_W-1];
         neg_y_ff <= req_stick_y[STICK_W-1];
         dt_ff    <= req_elapsed;
      end
      if ((state_ff == ST_ROOT) && !sqrt_busy) begin
         mag_ff <= sqrt_root;
      end
      if (state_ff == ST_MUL_DT_LO) begin
         hi_ff <= acc[MUL_A_W+MUL_B_W-1:MUL_A_W];
      end
   end

   // --------------------------------------------------------------------
   // response register
   // --------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == ST_REPLY) && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_REPLY) && rsp_free) begin
         rsp_cursor_x_ff <= PIX_W'(pixel_x_ff);
         rsp_cursor_y_ff <= PIX_W'(pixel_y_ff);
         rsp_moved_ff    <= moved_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_cursor_x = rsp_cursor_x_ff;
   assign rsp_cursor_y = rsp_cursor_y_ff;
   assign rsp_moved    = rsp_moved_ff;

endmodule

// File: design/asci_isqrt.sv
`timescale 1ns / 1ps

// Bit-pair integer square root, one result bit per cycle.
module asci_isqrt import asci_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [RAD_W-1:0]  radicand,
   output logic              busy,
   output logic [ROOT_W-1:0] root
);

   logic [RAD_W-1:0] rem_ff;
   logic [RAD_W-1:0] res_ff;
   logic [RAD_W-1:0] bit_ff;
   logic             busy_ff;
   logic [RAD_W-1:0] trial;
   logic             take;

   assign trial = res_ff + bit_ff;
   assign take  = (rem_ff >= trial);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
      end else if (busy_ff && (bit_ff == RAD_W'(1))) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= radicand;
         res_ff <= '0;
         bit_ff <= SQRT_TOP_BIT;
      end else if (busy_ff) begin
         if (take) begin
            rem_ff <= rem_ff - trial;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   assign busy = busy_ff;
   assign root = res_ff[ROOT_W-1:0];

endmodule

// File: design/asci_mac.sv
`timescale 1ns / 1ps

// Shared 32x16 multiplier with a 64-bit accumulator.
module asci_mac import asci_pkg::*; (
   input  logic             clock,
   input  mac_ctl_type      ctl,
   output logic [ACC_W-1:0] acc
);

   localparam int PROD_W = MUL_A_W + MUL_B_W;

   logic [ACC_W-1:0]  acc_ff;
   logic [ACC_W-1:0]  acc_in;
   logic [PROD_W-1:0] prod;

   assign prod = ctl.op_a * ctl.op_b;

   always_comb begin
      unique case (ctl.mode)
         MAC_LOAD:   acc_in = ACC_W'(prod);
         MAC_ADD:    acc_in = acc_ff + ACC_W'(prod);
         // upper partial product lands at bit 32
         MAC_ADD_HI: acc_in = acc_ff + {prod[31:0], 32'd0};
         default:    acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

// File: design/asci_port_check.sv
`timescale 1ns / 1ps

module asci_port_check import asci_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [PIX_W-1:0] rsp_cursor_x,
   input logic [PIX_W-1:0] rsp_cursor_y,
   input logic             rsp_moved
);

   // after reset: idle, nothing pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (req_ready && !rsp_valid))
      else $error("not idle after reset");

   // one transaction in work at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while busy");

   // a response only comes out of the busy phase
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("response without work");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_cursor_x) && $stable(rsp_cursor_y) && $stable(rsp_moved)))
      else $error("stalled response changed");

endmodule

bind analog_stick_cursor_integrator asci_port_check u_port_check (.*);

// File: test/analog_stick_cursor_integrator_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the analog stick cursor integrator.
// A driver and a monitor run as clocked always blocks; the driver pulls
// pending stick requests from a queue that the main initial block fills one
// phase at a time. Every accepted request goes through a local cursor
// predictor, and the response it should produce is queued for the monitor.
// Registers are only rewritten once the block has drained.
module analog_stick_cursor_integrator_tb;
   import asci_pkg::*;

   localparam int              FRAC        = 16;
   localparam int              CYCLE_LIMIT = 1_000_000;
   localparam int              LONG_HOLD   = 400;
   localparam logic [OP_W-1:0] OP_UNUSED   = 2'd3;
   // index 3 is not mapped, writes to it must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]           op;
      logic signed [STICK_W-1:0] sx;
      logic signed [STICK_W-1:0] sy;
      logic [DT_W-1:0]           elapsed;
      logic [PIX_W-1:0]          tx;
      logic [PIX_W-1:0]          ty;
   } stick_req_type;

   typedef struct packed {
      logic [PIX_W-1:0] x;
      logic [PIX_W-1:0] y;
      logic             moved;
   } cursor_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_IDX_W-1:0]      csr_index = '0;
   logic [CSR_DATA_W-1:0]     csr_wdata = '0;

   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [OP_W-1:0]           req_op = '0;
   logic signed [STICK_W-1:0] req_stick_x = '0;
   logic signed [STICK_W-1:0] req_stick_y = '0;
   logic [DT_W-1:0]           req_elapsed = '0;
   logic [PIX_W-1:0]          req_target_x = '0;
   logic [PIX_W-1:0]          req_target_y = '0;

   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [PIX_W-1:0]          rsp_cursor_x;
   logic [PIX_W-1:0]          rsp_cursor_y;
   logic                      rsp_moved;

   analog_stick_cursor_integrator DUT (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_op       (req_op),
      .req_stick_x  (req_stick_x),
      .req_stick_y  (req_stick_y),
      .req_elapsed  (req_elapsed),
      .req_target_x (req_target_x),
      .req_target_y (req_target_y),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_cursor_x (rsp_cursor_x),
      .rsp_cursor_y (rsp_cursor_y),
      .rsp_moved    (rsp_moved)
   );

   // 8 ns clock
   initial begin
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Cursor predictor: register shadows and position state
   // ---------------------------------------------------------------------
   logic [SPEED_W-1:0] speed_reg  = SPEED_RESET;
   logic [AREA_W-1:0]  width_reg  = WIDTH_RESET;
   logic [AREA_W-1:0]  height_reg = HEIGHT_RESET;

   logic [63:0]        pos_fine_x = '0;   // Q13.16 kept wide for the math
   logic [63:0]        pos_fine_y = '0;
   logic [PIX_W-1:0]   pos_pix_x  = '0;
   logic [PIX_W-1:0]   pos_pix_y  = '0;

   stick_req_type  stick_req_q[$];        // requests waiting for the driver
   cursor_rsp_type expected_cursor_q[$];  // responses the block still owes

   int launched = 0;     // requests put on the bus (driver)
   int accepted = 0;     // requests taken by the block (accept monitor)
   int err_cnt  = 0;
   int cycle_cnt = 0;
   bit idle_on  = 1'b1;  // random gaps on both sides
   int hold_asked = 0;   // bumped to ask the receiver for one long hold-off

   // zero means one pixel, anything past 2^13 saturates
   function automatic logic [AREA_W-1:0] usable_area(input logic [AREA_W-1:0] r);
      if (r == 0)
         return AREA_W'(1);
      if (r > (1 << PIX_W))
         return AREA_W'(1 << PIX_W);
      return r;
   endfunction

   // bitwise integer square root, floor
   function automatic logic [31:0] floor_sqrt(input logic [31:0] v);
      logic [31:0] root;
      logic [31:0] bitv;
      logic [31:0] rem;
      root = '0;
      rem  = v;
      bitv = SQRT_TOP_BIT;
      while (bitv > rem)
         bitv = bitv >> 2;
      while (bitv != 0) begin
         if (rem >= root + bitv) begin
            rem  = rem - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   // one axis: scale by magnitude, speed and time, then clamp into the area
   function automatic logic [63:0] step_axis(input logic [63:0] fine,
                                              input int s,
                                              input logic [31:0] mag,
                                              input logic [DT_W-1:0] dt,
                                              input logic [AREA_W-1:0] size);
      logic [63:0] step;
      logic [63:0] lim;
      logic [63:0] nxt;
      step = (s < 0) ? 64'(-s) : 64'(s);
      step = step * 64'(mag);
      step = step * 64'(speed_reg);
      step = step * 64'(dt);
      step = step >> (PRODUCT_FRAC - FRAC);   // magnitude truncates toward zero
      lim  = 64'(size - AREA_W'(1)) << FRAC;
      if (s < 0)
         nxt = (step > fine) ? 64'd0 : fine - step;
      else
         nxt = fine + step;
      if (nxt > lim)
         nxt = lim;
      return nxt;
   endfunction

   task automatic predict_cursor(input stick_req_type r);
      logic [AREA_W-1:0] w;
      logic [AREA_W-1:0] h;
      logic [31:0]       magsq;
      logic [31:0]       mag;
      logic [PIX_W-1:0]  nx;
      logic [PIX_W-1:0]  ny;
      logic [AREA_W-1:0] tx;
      logic [AREA_W-1:0] ty;
      int                sxi;
      int                syi;
      cursor_rsp_type    rsp;
      w   = usable_area(width_reg);
      h   = usable_area(height_reg);
      sxi = r.sx;
      syi = r.sy;
      rsp.moved = 1'b0;
      case (r.op)
         OP_TICK: begin
            magsq = 32'(sxi * sxi) + 32'(syi * syi);
            // dead zone and zero elapsed leave everything alone
            if (magsq > DEADZONE_SQ && r.elapsed != 0) begin
               mag        = floor_sqrt(magsq);
               pos_fine_x = step_axis(pos_fine_x, sxi, mag, r.elapsed, w);
               pos_fine_y = step_axis(pos_fine_y, syi, mag, r.elapsed, h);
               nx = pos_fine_x[FRAC +: PIX_W];
               ny = pos_fine_y[FRAC +: PIX_W];
               if (nx != pos_pix_x || ny != pos_pix_y) begin
                  pos_pix_x = nx;
                  pos_pix_y = ny;
                  rsp.moved = 1'b1;
               end
            end
         end
         OP_SET: begin
            tx = (AREA_W'(r.tx) > w - AREA_W'(1)) ? w - AREA_W'(1) : AREA_W'(r.tx);
            ty = (AREA_W'(r.ty) > h - AREA_W'(1)) ? h - AREA_W'(1) : AREA_W'(r.ty);
            pos_fine_x = 64'(tx) << FRAC;
            pos_fine_y = 64'(ty) << FRAC;
            pos_pix_x  = tx[PIX_W-1:0];
            pos_pix_y  = ty[PIX_W-1:0];
         end
         OP_CENTER: begin
            // half a pixel for odd sizes, no clamp
            pos_fine_x = (64'(w) << FRAC) >> 1;
            pos_fine_y = (64'(h) << FRAC) >> 1;
            pos_pix_x  = PIX_W'(w >> 1);
            pos_pix_y  = PIX_W'(h >> 1);
         end
         default: ;   // unused op: state untouched
      endcase
      rsp.x = pos_pix_x;
      rsp.y = pos_pix_y;
      expected_cursor_q.push_back(rsp);
   endtask

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   // mostly short gaps, now and then a long one
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 85)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic stick_req_type mk_req(input logic [OP_W-1:0] op,
                                            input int sx, input int sy,
                                            input int dt,
                                            input int tx, input int ty);
      stick_req_type r;
      r.op      = op;
      r.sx      = STICK_W'(sx);
      r.sy      = STICK_W'(sy);
      r.elapsed = DT_W'(dt);
      r.tx      = PIX_W'(tx);
      r.ty      = PIX_W'(ty);
      return r;
   endfunction

   // full scale, near the dead zone, or anything
   function automatic int rand_stick();
      case ($urandom_range(0, 9))
         0:       return -32768;
         1:       return 32767;
         2, 3:    return $urandom_range(0, 80) - 40;
         4:       return $urandom_range(0, 4000) - 2000;
         default: return int'($signed(16'($urandom)));
      endcase
   endfunction

   function automatic int rand_elapsed();
      case ($urandom_range(0, 9))
         0:       return 0;
         1:       return 65535;
         2, 3, 4: return $urandom_range(1, 255);
         5, 6:    return $urandom_range(256, 4095);
         default: return $urandom_range(0, 65535);
      endcase
   endfunction

   function automatic stick_req_type rand_req();
      int               r;
      logic [OP_W-1:0]  op;
      r = $urandom_range(0, 99);
      if (r < 72)
         op = OP_TICK;
      else if (r < 84)
         op = OP_SET;
      else if (r < 94)
         op = OP_CENTER;
      else
         op = OP_UNUSED;
      return mk_req(op, rand_stick(), rand_stick(), rand_elapsed(),
                    $urandom_range(0, 8191), $urandom_range(0, 8191));
   endfunction

   task automatic queue_random(input int n);
      repeat (n) stick_req_q.push_back(rand_req());
   endtask

   // block until the driver has nothing left and every response is back
   task automatic wait_drained();
      while (stick_req_q.size() != 0 || launched != accepted ||
             expected_cursor_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // register write; the shadow copy follows the transaction
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_SPEED:  speed_reg  = data[SPEED_W-1:0];
         CSR_WIDTH:  width_reg  = data[AREA_W-1:0];
         CSR_HEIGHT: height_reg = data[AREA_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Request driver: new transaction only after the previous one is taken
   // ---------------------------------------------------------------------
   int            send_gap = 0;
   stick_req_type cur_req;

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (launched != accepted) begin
         // still waiting on req_ready, hold payload
      end else if (send_gap > 0) begin
         send_gap = send_gap - 1;
         req_valid <= 1'b0;
      end else if (stick_req_q.size() != 0) begin
         cur_req = stick_req_q.pop_front();
         req_op       <= cur_req.op;
         req_stick_x  <= cur_req.sx;
         req_stick_y  <= cur_req.sy;
         req_elapsed  <= cur_req.elapsed;
         req_target_x <= cur_req.tx;
         req_target_y <= cur_req.ty;
         req_valid    <= 1'b1;
         launched = launched + 1;
         if (idle_on && $urandom_range(0, 2) == 0)
            send_gap = idle_len();
      end else begin
         req_valid <= 1'b0;
      end
   end

   // accepted requests feed the predictor
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         predict_cursor(mk_req(req_op, req_stick_x, req_stick_y, req_elapsed,
                               req_target_x, req_target_y));
         accepted = accepted + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Response side: random back-pressure plus one long hold-off on request
   // ---------------------------------------------------------------------
   int stall_left = 0;
   int hold_seen  = 0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_seen != hold_asked) begin
         hold_seen  = hold_asked;
         stall_left = LONG_HOLD - 1;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
         stall_left = idle_len() - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // response checker
   always @(posedge clock) begin
      cursor_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_cursor_q.size() == 0) begin
            $error("response with nothing outstanding: x=%0d y=%0d moved=%0d",
                   rsp_cursor_x, rsp_cursor_y, rsp_moved);
            err_cnt = err_cnt + 1;
         end else begin
            want = expected_cursor_q.pop_front();
            if (rsp_cursor_x !== want.x) begin
               $error("cursor_x mismatch: expected %0d, got %0d", want.x, rsp_cursor_x);
               err_cnt = err_cnt + 1;
            end
            if (rsp_cursor_y !== want.y) begin
               $error("cursor_y mismatch: expected %0d, got %0d", want.y, rsp_cursor_y);
               err_cnt = err_cnt + 1;
            end
            if (rsp_moved !== want.moved) begin
               $error("moved mismatch: expected %0d, got %0d", want.moved, rsp_moved);
               err_cnt = err_cnt + 1;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_cnt = cycle_cnt + 1;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // --- directed, reset register values (1200 px/s, 640x480) ---
      stick_req_q.push_back(mk_req(OP_TICK, 0, 0, 65535, 0, 0));        // dead zone
      stick_req_q.push_back(mk_req(OP_CENTER, 0, 0, 0, 0, 0));
      stick_req_q.push_back(mk_req(OP_TICK, 32767, 0, 65535, 0, 0));    // full +x
      stick_req_q.push_back(mk_req(OP_TICK, -32768, -32768, 65535, 0, 0)); // pin to 0
      stick_req_q.push_back(mk_req(OP_TICK, 32767, 32767, 65535, 0, 0));  // pin to max
      stick_req_q.push_back(mk_req(OP_CENTER, 0, 0, 0, 0, 0));
      stick_req_q.push_back(mk_req(OP_TICK, 32, 7, 65535, 0, 0));       // magsq on the edge
      stick_req_q.push_back(mk_req(OP_TICK, 32, 8, 65535, 0, 0));       // just past it
      stick_req_q.push_back(mk_req(OP_TICK, -7, -32, 65535, 0, 0));
      stick_req_q.push_back(mk_req(OP_TICK, 32767, -32768, 0, 0, 0));   // zero elapsed
      stick_req_q.push_back(mk_req(OP_TICK, -20000, 15000, 1, 0, 0));   // sub-pixel step
      stick_req_q.push_back(mk_req(OP_TICK, 9000, -12000, 700, 0, 0));
      stick_req_q.push_back(mk_req(OP_SET, 0, 0, 0, 8191, 8191));       // clamps to area
      stick_req_q.push_back(mk_req(OP_SET, 0, 0, 0, 0, 0));
      stick_req_q.push_back(mk_req(OP_TICK, -32768, -1, 65535, 0, 0));
      stick_req_q.push_back(mk_req(OP_SET, 0, 0, 0, 639, 479));
      stick_req_q.push_back(mk_req(OP_TICK, 32767, 32767, 300, 0, 0));
      stick_req_q.push_back(mk_req(OP_SET, 0, 0, 0, 640, 480));
      stick_req_q.push_back(mk_req(OP_SET, 0, 0, 0, 123, 321));
      stick_req_q.push_back(mk_req(OP_UNUSED, -1, -1, 65535, 8191, 8191));
      stick_req_q.push_back(mk_req(OP_UNUSED, 0, 0, 0, 0, 0));
      stick_req_q.push_back(mk_req(OP_TICK, -1, 32767, 65535, 0, 0));
      queue_random(140);
      wait_drained();

      // --- largest settings ---
      write_reg(CSR_SPEED, 16'hFFFF);
      write_reg(CSR_WIDTH, 16'd8192);
      write_reg(CSR_HEIGHT, 16'd8192);
      stick_req_q.push_back(mk_req(OP_SET, 0, 0, 0, 8191, 8191));
      stick_req_q.push_back(mk_req(OP_TICK, 32767, 32767, 65535, 0, 0));
      stick_req_q.push_back(mk_req(OP_CENTER, 0, 0, 0, 0, 0));
      stick_req_q.push_back(mk_req(OP_TICK, -32768, -32768, 65535, 0, 0));
      stick_req_q.push_back(mk_req(OP_SET, 0, 0, 0, 7000, 6000));
      queue_random(150);
      wait_drained();

      // --- zero speed, one pixel area; position not re-clamped until used ---
      write_reg(CSR_SPEED, 16'd0);
      write_reg(CSR_WIDTH, 16'd0);
      write_reg(CSR_HEIGHT, 16'd1);
      stick_req_q.push_back(mk_req(OP_UNUSED, 0, 0, 0, 0, 0));     // stale pixel
      stick_req_q.push_back(mk_req(OP_TICK, 32767, 32767, 65535, 0, 0));
      stick_req_q.push_back(mk_req(OP_CENTER, 0, 0, 0, 0, 0));     // half pixel
      stick_req_q.push_back(mk_req(OP_TICK, -32768, 32767, 65535, 0, 0));
      queue_random(90);
      wait_drained();
      write_reg(CSR_SPEED, 16'd1);
      queue_random(30);
      wait_drained();

      // --- saturating area registers, unmapped index ---
      write_reg(CSR_WIDTH, 16'h3FFF);
      write_reg(CSR_HEIGHT, 16'd8193);
      write_reg(CSR_SPEED, 16'($urandom));
      write_reg(CSR_UNMAPPED, 16'hFFFF);
      stick_req_q.push_back(mk_req(OP_SET, 0, 0, 0, 8191, 8191));
      stick_req_q.push_back(mk_req(OP_CENTER, 0, 0, 0, 0, 0));
      queue_random(150);
      wait_drained();

      // --- small odd areas, no idling on either side ---
      idle_on = 1'b0;
      write_reg(CSR_SPEED, 16'($urandom_range(1, 300)));
      write_reg(CSR_WIDTH, 16'($urandom_range(1, 64)) | 16'd1);
      write_reg(CSR_HEIGHT, 16'($urandom_range(1, 64)) | 16'd1);
      stick_req_q.push_back(mk_req(OP_CENTER, 0, 0, 0, 0, 0));
      queue_random(150);
      wait_drained();
      idle_on = 1'b1;

      // --- random register words (upper bits too) and a long receiver stall ---
      write_reg(CSR_SPEED, 16'($urandom));
      write_reg(CSR_WIDTH, 16'($urandom));
      write_reg(CSR_HEIGHT, 16'($urandom));
      write_reg(CSR_UNMAPPED, 16'($urandom));
      hold_asked = hold_asked + 1;   // receiver stalls while requests keep coming
      queue_random(110);
      wait_drained();
      write_reg(CSR_SPEED, 16'($urandom_range(100, 5000)));
      write_reg(CSR_WIDTH, 16'($urandom_range(100, 2000)));
      write_reg(CSR_HEIGHT, 16'($urandom_range(100, 2000)));
      queue_random(110);

      wait_drained();
      repeat (50) @(posedge clock);   // catch any stray response
      if (err_cnt == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// File: filelist.f
design/asci_pkg.sv
design/asci_isqrt.sv
design/asci_mac.sv
design/analog_stick_cursor_integrator.sv
design/asci_port_check.sv
test/analog_stick_cursor_integrator_tb.sv
